/* src/ip_frame_crc16_framer_assert.svh */
// assertion macros for the ip frame crc16 framer checker
// used by the checker file only; relies on clk and rst in the enclosing scope
`ifndef IP_FRAME_CRC16_FRAMER_ASSERT_SVH
`define IP_FRAME_CRC16_FRAMER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define IPFCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer check failed");

// next-cycle implication, disabled while in reset
`define IPFCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

/* src/ipfcf_pkg.sv */
// shared types, constants and the crc-16/modbus byte update for the framer
// no dependencies
package ipfcf_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] HDR_LEN  = 8'd3;
  localparam logic [7:0] HDR_TYPE = 8'd1;
  localparam logic [7:0] HDR_NEXT = 8'd4;

  // position of a word inside one item's output sequence
  localparam int SLOT_W = 3;
  localparam logic [SLOT_W-1:0] SLOT_HDR0   = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_HDR1   = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_HDR2   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_DATA   = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_CRC_LO = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_CRC_HI = 3'd5;

  // one accepted byte with everything the emitter needs
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        first;
    logic [15:0] crc;
  } item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // crc after the fixed header, worked out at elaboration
  localparam logic [15:0] CRC_HDR = crc_byte(crc_byte(crc_byte(CRC_INIT, HDR_LEN),
                                                      HDR_TYPE), HDR_NEXT);

endpackage

/* src/ipfcf_in_stage.sv */
// input stage: takes one packet byte, updates the running crc, holds the item
// depends on ipfcf_pkg
module ipfcf_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // data_byte
  input  logic                s_tlast,   // last_byte
  output logic                item_valid,
  input  logic                item_ready,
  output ipfcf_pkg::item_t    item
);

  logic [15:0] crc_accum;
  logic [15:0] crc_accum_next;
  logic        inside_packet;
  logic        item_valid_r;
  logic [15:0] crc_start;
  logic [15:0] crc_new;
  logic        take;

  assign s_tready   = !item_valid_r || item_ready;
  assign take       = s_tvalid && s_tready;
  assign item_valid = item_valid_r;

  // a new packet starts from the crc of the fixed header
  assign crc_start      = inside_packet ? crc_accum : ipfcf_pkg::CRC_HDR;
  assign crc_new        = ipfcf_pkg::crc_byte(crc_start, s_tdata);
  assign crc_accum_next = s_tlast ? ipfcf_pkg::CRC_INIT : crc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum     <= ipfcf_pkg::CRC_INIT;
      inside_packet <= 1'b0;
      item_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        crc_accum     <= crc_accum_next;
        inside_packet <= !s_tlast;
        item_valid_r  <= 1'b1;
      end else if (item_ready) begin
        item_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.data  <= s_tdata;
      item.last  <= s_tlast;
      item.first <= !inside_packet;
      item.crc   <= crc_new;
    end
  end

endmodule

/* src/ipfcf_emit.sv */
// emitter: walks one item's words (header, data, crc) into the output register
// depends on ipfcf_pkg
module ipfcf_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  ipfcf_pkg::item_t    item,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // frame_byte
  output logic                m_tlast    // frame_end
);

  logic [ipfcf_pkg::SLOT_W-1:0] cnt;
  logic [ipfcf_pkg::SLOT_W-1:0] slot;
  logic [ipfcf_pkg::SLOT_W-1:0] slot_end;
  logic                         out_valid;
  logic                         load;
  logic                         at_end;
  logic [7:0]                   byte_sel;
  logic                         end_sel;

  // later bytes of a packet skip the header slots
  assign slot     = cnt + (item.first ? ipfcf_pkg::SLOT_HDR0 : ipfcf_pkg::SLOT_DATA);
  assign slot_end = item.last ? ipfcf_pkg::SLOT_CRC_HI : ipfcf_pkg::SLOT_DATA;
  assign load     = item_valid && (!out_valid || m_tready);
  assign at_end   = (slot == slot_end);
  assign item_ready = load && at_end;

  always_comb begin
    byte_sel = item.data;
    end_sel  = 1'b0;
    unique case (slot)
      ipfcf_pkg::SLOT_HDR0:   byte_sel = ipfcf_pkg::HDR_LEN;
      ipfcf_pkg::SLOT_HDR1:   byte_sel = ipfcf_pkg::HDR_TYPE;
      ipfcf_pkg::SLOT_HDR2:   byte_sel = ipfcf_pkg::HDR_NEXT;
      ipfcf_pkg::SLOT_DATA:   byte_sel = item.data;
      ipfcf_pkg::SLOT_CRC_LO: byte_sel = item.crc[7:0];
      ipfcf_pkg::SLOT_CRC_HI: begin
        byte_sel = item.crc[15:8];
        end_sel  = 1'b1;
      end
      default:                byte_sel = item.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt       <= at_end ? '0 : cnt + 1'b1;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_sel;
      m_tlast <= end_sel;
    end
  end

  assign m_tvalid = out_valid;

endmodule

/* src/ip_frame_crc16_framer.sv */
// an accepted byte goes to the item register, then its words to the output register
// one output word per cycle unless stalled; a packet of n bytes yields n + 5 words
// an input byte is taken every cycle while it yields a single word and the output
// is not stalled; the first and last bytes of a packet hold the input for the extra
// header and crc words; reset (rst, synchronous, active high) clears the crc to
// 0xffff, marks no packet open and empties the item and output registers
module ip_frame_crc16_framer (
  input  logic       clk,
  input  logic       rst,
  // packet side
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte [7:0]
  input  logic       s_tlast,   // last_byte
  // link side
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // frame_byte [7:0]
  output logic       m_tlast    // frame_end, on the high crc word
);

  // item handoff between the crc stage and the emitter
  logic             item_valid;
  logic             item_ready;
  ipfcf_pkg::item_t item;

  // running crc and the registered item; the crc of a byte is ready here
  ipfcf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // sequences header, data and crc words into the output register
  ipfcf_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

/* src/ipfcf_checker.sv */
// port-level checks for the framer, bound to the top level
// depends on ip_frame_crc16_framer_assert.svh
`include "ip_frame_crc16_framer_assert.svh"

module ipfcf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // a stalled output word holds
  `IPFCF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // input is only held back while work is pending, so a word shows next cycle
  `IPFCF_ASSERT_NEXT(a_busy_out, !s_tready, m_tvalid)

  // a frame is at least six words, so two frame ends never follow directly
  `IPFCF_ASSERT_NEXT(a_end_gap, m_tvalid && m_tready && m_tlast, !(m_tvalid && m_tlast))

  // output is empty right after reset
  `IPFCF_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid)

endmodule

bind ip_frame_crc16_framer ipfcf_checker u_chk (.*);
